// ===== hw/rtl/kph_pkg.sv =====
// kph_pkg: shared types and codes for the k-mer prefix histogram core.
// No dependencies.
package kph_pkg;

	typedef enum logic [1:0] {
		ACT_BASE  = 2'd0,
		ACT_EOS   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	localparam logic [2:0] KMER_LENGTH_RST = 3'd7;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  base_char;
		logic [2:0]  read_order;
		logic [13:0] read_index;
	} kph_in_t;

	typedef struct packed {
		logic [31:0] count_value;
		logic        is_saturated;
	} kph_out_t;

	// status from the back part to the front part
	typedef struct packed {
		logic init_clear;
	} kph_back_stat_t;

endpackage

// ===== hw/rtl/kph_ram.sv =====
// kph_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/kph_fifo.sv =====
// kph_fifo: two-entry command queue between front and back parts.
// No dependencies.
module kph_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_en,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = ent_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hw/rtl/kph_front.sv =====
// kph_front: accepts transactions, codes bases, keeps the two windows
// and fill count, and queues commands for the back part. Uses kph_pkg.
module kph_front #(
	parameter int MAX_K = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0]               kmer_length,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  kph_pkg::kph_in_t         in_data,
	input  kph_pkg::kph_back_stat_t  stat,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output logic [2+((($clog2(MAX_K+1))>3)?($clog2(MAX_K+1)):3)+4*MAX_K-1:0] cmd_data
);
	localparam int WB = 2 * MAX_K;
	localparam int KW = $clog2(MAX_K + 1);
	localparam int OW = (KW > 3) ? KW : 3;

	logic [WB-1:0] fwd_q, rev_q, fwd_n, rev_n, fk, rk, kmask;
	logic [KW-1:0] fill_q, k_eff;
	logic [1:0]    fcode, rcode;
	logic          acc, do_bump;
	kph_pkg::act_t act;

	assign act      = kph_pkg::act_t'(in_data.action);
	assign in_ready = cmd_ready && !stat.init_clear;
	assign acc      = in_valid && in_ready;

	always_comb begin
		if (kmer_length == 3'd0) k_eff = KW'(1);
		else if (int'(kmer_length) > MAX_K) k_eff = KW'(MAX_K);
		else k_eff = KW'(kmer_length);
	end

	always_comb begin
		case (in_data.base_char)
			8'h41, 8'h61: begin fcode = 2'd0; rcode = 2'd3; end
			8'h47, 8'h67: begin fcode = 2'd1; rcode = 2'd2; end
			8'h43, 8'h63: begin fcode = 2'd2; rcode = 2'd1; end
			8'h54, 8'h74: begin fcode = 2'd3; rcode = 2'd0; end
			default:      begin fcode = 2'd0; rcode = 2'd0; end
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			kmask[2*i+:2] = (i < int'(k_eff)) ? 2'b11 : 2'b00;
		end
	end

	assign fwd_n   = {fwd_q[WB-3:0], fcode};
	assign rev_n   = {rcode, rev_q[WB-1:2]};
	assign fk      = fwd_n & kmask;
	assign rk      = rev_n >> (2 * (MAX_K - int'(k_eff)));
	assign do_bump = !(fill_q < k_eff);

	always_comb begin
		cmd_valid = 1'b0;
		cmd_data  = {in_data.action, OW'(k_eff), fk, rk};
		case (act)
			kph_pkg::ACT_BASE:  cmd_valid = in_valid && do_bump && !stat.init_clear;
			kph_pkg::ACT_READ: begin
				cmd_valid = in_valid && !stat.init_clear;
				cmd_data  = {in_data.action, OW'(in_data.read_order),
					WB'(in_data.read_index), WB'(0)};
			end
			kph_pkg::ACT_CLEAR: cmd_valid = in_valid && !stat.init_clear;
			default:            cmd_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= KW'(1);
		end else if (acc) begin
			if (act == kph_pkg::ACT_BASE) begin
				fwd_q <= fwd_n;
				rev_q <= rev_n;
				if (!do_bump) fill_q <= fill_q + KW'(1);
			end else if (act == kph_pkg::ACT_EOS) begin
				fwd_q  <= '0;
				rev_q  <= '0;
				fill_q <= KW'(1);
			end
		end
	end
endmodule

// ===== hw/rtl/kph_back.sv =====
// kph_back: sequencer that runs counter updates, reads and clears on the
// count store. Uses kph_pkg and kph_ram.
module kph_back #(
	parameter int MAX_K      = 7,
	parameter int COUNT_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_pop,
	input  logic [2+((($clog2(MAX_K+1))>3)?($clog2(MAX_K+1)):3)+4*MAX_K-1:0] cmd_data,
	output kph_pkg::kph_back_stat_t stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output kph_pkg::kph_out_t       out_data
);
	localparam int WB    = 2 * MAX_K;
	localparam int KW    = $clog2(MAX_K + 1);
	localparam int OW    = (KW > 3) ? KW : 3;
	localparam int DEPTH = ((1 << (2 * (MAX_K + 1))) - 1) / 3;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {B_CLR, B_IDLE, B_RD, B_WR, B_RQ, B_RDATA} st_t;

	st_t              st_q;
	logic             init_q, side_q, out_valid_q;
	logic [OW-1:0]    ord_q;
	logic [WB-1:0]    fk_q, rk_q, code, code_m;
	logic [AW-1:0]    clr_q, addr_q, base, addr;
	logic [COUNT_BITS-1:0] rdata;
	kph_pkg::kph_out_t out_q;
	logic [1:0]       c_act;
	logic [OW-1:0]    c_ord;
	logic [WB-1:0]    c_fk, c_rk;
	logic             ram_we, ram_re, sat, slot_free;
	logic [COUNT_BITS-1:0] wdata;
	logic [AW-1:0]    waddr;

	assign {c_act, c_ord, c_fk, c_rk} = cmd_data;
	assign cmd_pop   = (st_q == B_IDLE) && cmd_valid;
	assign code      = side_q ? rk_q : fk_q;
	assign sat       = &rdata;
	assign slot_free = !out_valid_q || out_ready;

	// prefix address: offset of order L is 0101..01 (L pairs), plus masked code
	always_comb begin
		base   = '0;
		code_m = '0;
		for (int i = 0; i < MAX_K; i++) begin
			if (i < int'(ord_q)) begin
				base[2*i]     = 1'b1;
				code_m[2*i+:2] = code[2*i+:2];
			end
		end
		addr = base + AW'(code_m);
	end

	assign ram_re = (st_q == B_RD) || (st_q == B_RQ);
	assign ram_we = (st_q == B_WR) || (st_q == B_CLR);
	assign waddr  = (st_q == B_CLR) ? clr_q : addr_q;
	assign wdata  = (st_q == B_CLR) ? '0 : (sat ? rdata : rdata + COUNT_BITS'(1));

	kph_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
		.re(ram_re), .raddr(addr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_CLR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			side_q      <= 1'b0;
			ord_q       <= '0;
			fk_q        <= '0;
			rk_q        <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// B_RDATA refills the slot itself when it frees
			if (out_valid_q && out_ready && st_q != B_RDATA) out_valid_q <= 1'b0;
			case (st_q)
				B_CLR: begin
					if (int'(clr_q) == DEPTH - 1) begin
						clr_q  <= '0;
						init_q <= 1'b0;
						st_q   <= B_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				B_IDLE: begin
					if (cmd_valid) begin
						ord_q  <= c_ord;
						fk_q   <= c_fk;
						rk_q   <= c_rk;
						side_q <= 1'b0;
						case (kph_pkg::act_t'(c_act))
							kph_pkg::ACT_BASE:  st_q <= B_RD;
							kph_pkg::ACT_READ:  st_q <= B_RQ;
							kph_pkg::ACT_CLEAR: st_q <= B_CLR;
							default:            st_q <= B_IDLE;
						endcase
					end
				end
				B_RD: begin
					addr_q <= addr;
					st_q   <= B_WR;
				end
				B_WR: begin
					if (!side_q) begin
						side_q <= 1'b1;
						st_q   <= B_RD;
					end else if (ord_q == '0) begin
						st_q <= B_IDLE;
					end else begin
						side_q <= 1'b0;
						ord_q  <= ord_q - OW'(1);
						fk_q   <= fk_q >> 2;
						rk_q   <= rk_q >> 2;
						st_q   <= B_RD;
					end
				end
				B_RQ: st_q <= B_RDATA;
				B_RDATA: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (int'(ord_q) > MAX_K) begin
							out_q <= '0;
						end else begin
							out_q.count_value  <= 32'(rdata);
							out_q.is_saturated <= sat;
						end
						st_q <= B_IDLE;
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign stat.init_clear = init_q;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re)) else $error("store read and write in one cycle");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_WR |-> $past(st_q) == B_RD) else $error("update without read");
	a_init_clr: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> st_q == B_CLR) else $error("init clear left early");
	a_clr_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_CLR && int'(clr_q) == DEPTH - 1) |=> st_q == B_IDLE)
		else $error("clear pass overran");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !init_q) else $error("command taken during init clear");
endmodule

// ===== hw/rtl/kmer_prefix_histogram_core.sv =====
// kmer_prefix_histogram_core: top level; config register, front, queue, back.
// Uses kph_pkg, kph_front, kph_fifo, kph_back.
// In the back part, a base that counts is a read then a write of one store port
// for each of two prefixes per order; a read is one store read and its result.
// End of sequence and bases still filling the window are handled in the front.
// Reset: windows zero, k = 7, then a clearing pass zeroes all (4^(MAX_K+1)-1)/3
// store entries; no transaction is accepted until it ends.
module kmer_prefix_histogram_core #(
	parameter int MAX_K      = 7,
	parameter int COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  kph_pkg::kph_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output kph_pkg::kph_out_t out_data
);
	localparam int KW = $clog2(MAX_K + 1);
	localparam int OW = (KW > 3) ? KW : 3;
	localparam int CW = 2 + OW + 4 * MAX_K;

	logic [2:0]              kmer_length_q;
	logic                    fq_valid, fq_ready, bq_valid, bq_pop;
	logic [CW-1:0]           fq_data, bq_data;
	kph_pkg::kph_back_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= kph_pkg::KMER_LENGTH_RST;
		end else if (cfg_wr_en) begin
			kmer_length_q <= cfg_wr_data;
		end
	end

	kph_front #(.MAX_K(MAX_K)) u_front (
		.clk(clk), .arst_n(arst_n), .kmer_length(kmer_length_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.stat(stat), .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd_data(fq_data)
	);

	kph_fifo #(.W(CW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_en(bq_pop), .rd_data(bq_data)
	);

	kph_back #(.MAX_K(MAX_K), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(bq_valid), .cmd_pop(bq_pop), .cmd_data(bq_data),
		.stat(stat), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for kmer_prefix_histogram_core.
// Depends on kph_pkg and the core RTL; carries its own histogram predictor.
module tb_top;
	import kph_pkg::*;

	localparam int MAX_K       = 7;
	localparam int STORE_DEPTH = 21845;
	localparam int WDOG_LIMIT  = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		kph_in_t     item;
		bit          typed;
		logic [31:0] count;
		logic        sat;
	} dir_row_t;

	typedef struct {
		logic [31:0] count;
		logic        sat;
	} count_exp_t;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_wr_en = 0;
	logic [2:0] cfg_wr_data = '0;
	logic      in_valid = 0;
	logic      in_ready;
	kph_in_t   in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	kph_out_t  out_data;

	// predictor state
	logic [13:0] fwd_win, rev_win;
	int          fill_cnt;
	logic [2:0]  klen;
	logic [31:0] hist [0:STORE_DEPTH-1];

	count_exp_t  exp_counts[$];
	dir_row_t    dir_tab[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	always #2 clk = ~clk;

	kmer_prefix_histogram_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	function automatic int order_base(int order);
		return ((1 << (2 * order)) - 1) / 3;
	endfunction

	function automatic void hist_bump(int order, logic [13:0] code);
		int at;
		at = order_base(order) + int'(code & 14'((1 << (2 * order)) - 1));
		if (hist[at] != 32'hFFFF_FFFF)
			hist[at] = hist[at] + 32'd1;
	endfunction

	function automatic void hist_reset();
		for (int i = 0; i < STORE_DEPTH; i++)
			hist[i] = '0;
	endfunction

	// advance the predictor by one transaction, queue a read's expected value
	function automatic void hist_predict(kph_in_t it, bit typed, logic [31:0] tc, logic tsat);
		logic [1:0]  fc, rc;
		logic [13:0] fk, rk;
		int          k, at;
		count_exp_t  e;
		case (act_t'(it.action))
			ACT_BASE: begin
				case (it.base_char)
					"A", "a": begin fc = 2'd0; rc = 2'd3; end
					"G", "g": begin fc = 2'd1; rc = 2'd2; end
					"C", "c": begin fc = 2'd2; rc = 2'd1; end
					"T", "t": begin fc = 2'd3; rc = 2'd0; end
					default: begin fc = 2'd0; rc = 2'd0; end
				endcase
				fwd_win = {fwd_win[11:0], fc};
				rev_win = {rc, rev_win[13:2]};
				k = (klen == 3'd0) ? 1 : int'(klen);
				if (fill_cnt < k) begin
					fill_cnt++;
				end else begin
					fk = fwd_win & 14'((1 << (2 * k)) - 1);
					rk = rev_win >> (2 * (MAX_K - k));
					for (int o = k; o >= 0; o--) begin
						hist_bump(o, fk);
						hist_bump(o, rk);
						fk = fk >> 2;
						rk = rk >> 2;
					end
				end
			end
			ACT_EOS: begin
				fwd_win = '0;
				rev_win = '0;
				fill_cnt = 1;
			end
			ACT_CLEAR: hist_reset();
			ACT_READ: begin
				at = order_base(int'(it.read_order)) +
					int'(it.read_index & 14'((1 << (2 * it.read_order)) - 1));
				e.count = hist[at];
				e.sat = (hist[at] == 32'hFFFF_FFFF);
				if (typed) begin
					e.count = tc;
					e.sat = tsat;
				end
				exp_counts.push_back(e);
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(kph_in_t it, bit typed = 0, logic [31:0] tc = 0, logic tsat = 0);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		hist_predict(it, typed, tc, tsat);
		@(negedge clk);
	endtask

	task automatic drain_and_config(logic [2:0] k);
		in_valid <= 0;
		wait (exp_counts.size() == 0);
		repeat (50) @(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= k;
		@(negedge clk);
		cfg_wr_en <= 0;
		klen = k;
	endtask

	function automatic kph_in_t mk(act_t a, logic [7:0] c, logic [2:0] o, logic [13:0] i);
		kph_in_t it;
		it.action = a;
		it.base_char = c;
		it.read_order = o;
		it.read_index = i;
		return it;
	endfunction

	function automatic void add_row(kph_in_t it, bit typed = 0, logic [31:0] c = 0);
		dir_row_t r;
		r.item = it;
		r.typed = typed;
		r.count = c;
		r.sat = 0;
		dir_tab.push_back(r);
	endfunction

	function automatic kph_in_t rand_item();
		kph_in_t     it;
		int          r;
		logic [7:0]  alpha [8] = '{"A", "G", "C", "T", "a", "g", "c", "t"};
		it = '0;
		it.base_char = $urandom_range(0, 255);
		it.read_order = $urandom_range(0, 7);
		it.read_index = $urandom_range(0, 16383);
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 249) == 0)
			it.action = ACT_CLEAR;
		else if (r < 78) begin
			it.action = ACT_BASE;
			if ($urandom_range(0, 9) != 0)
				it.base_char = alpha[$urandom_range(0, 7)];
		end else if (r < 84)
			it.action = ACT_EOS;
		else begin
			it.action = ACT_READ;
			// mostly aim at the forward window, so reads at k = 7 hit prefixes just counted
			if ($urandom_range(0, 3) != 0)
				it.read_index = fwd_win >> (2 * (MAX_K - it.read_order));
		end
		return it;
	endfunction

	// receiver: random stall bursts, one long hold on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 5);
				out_ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		count_exp_t e;
		if (out_valid && out_ready) begin
			if (exp_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected read result count=%0d sat=%0b",
						out_data.count_value, out_data.is_saturated);
			end else begin
				e = exp_counts.pop_front();
				if (out_data.count_value !== e.count || out_data.is_saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read mismatch: exp count=%0d sat=%0b got count=%0d sat=%0b",
							e.count, e.sat, out_data.count_value, out_data.is_saturated);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		static logic [2:0] phase_k [8] = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4, 3'd7};
		int         waited;
		fwd_win = '0;
		rev_win = '0;
		fill_cnt = 1;
		klen = KMER_LENGTH_RST;
		hist_reset();

		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed part at k = 1
		add_row(mk(ACT_READ, 0, 0, 0), 1, 0);
		add_row(mk(ACT_READ, 0, 7, 14'h3FFF), 1, 0);
		add_row(mk(ACT_BASE, "A", 0, 0));
		add_row(mk(ACT_READ, 0, 0, 14'h3FFF), 1, 2);
		add_row(mk(ACT_READ, 0, 1, 0), 1, 1);
		add_row(mk(ACT_READ, 0, 1, 14'h3FFF), 1, 1);
		add_row(mk(ACT_BASE, "a", 0, 0));
		add_row(mk(ACT_BASE, "G", 0, 0));
		add_row(mk(ACT_BASE, "g", 0, 0));
		add_row(mk(ACT_BASE, "C", 0, 0));
		add_row(mk(ACT_BASE, "c", 0, 0));
		add_row(mk(ACT_BASE, "T", 0, 0));
		add_row(mk(ACT_BASE, "t", 0, 0));
		add_row(mk(ACT_BASE, "N", 0, 0));
		add_row(mk(ACT_BASE, 8'hFF, 0, 0));
		add_row(mk(ACT_BASE, 8'h00, 0, 0));
		add_row(mk(ACT_READ, 0, 1, 1)); add_row(mk(ACT_READ, 0, 1, 2));
		add_row(mk(ACT_READ, 0, 1, 14'h3FFC)); add_row(mk(ACT_READ, 0, 0, 0));
		add_row(mk(ACT_EOS, 0, 0, 0));
		add_row(mk(ACT_READ, 0, 1, 3));
		add_row(mk(ACT_CLEAR, 0, 0, 0));
		add_row(mk(ACT_READ, 0, 0, 0), 1, 0);

		drain_and_config(3'd1);
		foreach (dir_tab[i])
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].count, dir_tab[i].sat);

		for (int p = 0; p < 8; p++) begin
			drain_and_config(phase_k[p]);
			if (p == 7)
				quiet = 1;
			for (int n = 0; n < 115; n++) begin
				if (p == 1 && n == 40)
					hold_req = 1;
				if (p == 2 && n == 60) begin
					in_valid <= 0;
					wait (exp_counts.size() == 0);
					@(negedge clk);
				end
				send_item(rand_item());
			end
			// a closing read means the block is idle once its result is back
			send_item(mk(ACT_READ, 0, 0, 0));
		end

		in_valid <= 0;
		wait (exp_counts.size() == 0);
		waited = 0;
		while (waited < 100 && !out_valid) begin
			@(posedge clk);
			waited++;
		end
		@(posedge clk);
		if (mismatches == 0 && exp_counts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/kph_pkg.sv
hw/rtl/kph_ram.sv
hw/rtl/kph_fifo.sv
hw/rtl/kph_front.sv
hw/rtl/kph_back.sv
hw/rtl/kmer_prefix_histogram_core.sv
dv/tb_top.sv
